@@ rtl/plst_pkg.sv @@
// Package for the positional list store.
// Holds shared widths, opcode and status codes, the engine state type and the result struct.
// No dependencies.
package plst_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int POS_W        = 6;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 6;

    // Requested operations.
    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } t_opcode;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Engine sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

    // One finished result, handed from the engine to the output register.
    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
    } t_result;

endpackage

@@ rtl/plst_engine.sv @@
// List engine: entry memory, element count and the sequencer that shifts entries.
// Depends on plst_pkg.
module plst_engine #(
    parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic [1:0]                       i_opcode,
    input  logic [plst_pkg::POS_W-1:0]       i_position,
    input  logic signed [plst_pkg::DATA_W-1:0] i_value_in,
    output logic                             o_busy,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output plst_pkg::t_result                o_res
);
    import plst_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = ((FW > POS_W) ? FW : POS_W) + 1;

    t_state                   r_state, n_state;
    t_opcode                  r_op, n_op;
    logic [CW-1:0]            r_pos, n_pos;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [FW-1:0]            r_fill, n_fill;
    logic [FW-1:0]            r_left, n_left;
    logic [AW-1:0]            r_rd_addr, n_rd_addr;
    logic                     r_wr_pend, n_wr_pend;
    logic [AW-1:0]            r_wr_addr, n_wr_addr;
    logic                     r_status, n_status;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic signed [DATA_W-1:0] r_rd_data;

    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic                     mem_re;
    logic [AW-1:0]            mem_ra;
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic signed [DATA_W-1:0] mem_wd;

    logic [CW-1:0] pos_x;
    logic [CW-1:0] fill_x;
    logic          ok_read;
    logic          ok_insert;
    logic          is_insert;

    // Range checks on the incoming request against the current count.
    assign pos_x     = CW'(i_position);
    assign fill_x    = CW'(r_fill);
    assign ok_read   = (pos_x != '0) && (pos_x <= fill_x);
    assign ok_insert = (fill_x < CW'(CAPACITY)) && (pos_x != '0) && (pos_x <= fill_x + 1'b1);
    assign is_insert = (r_op == OP_INSERT);

    // Entry memory: one write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_wr_pend <= n_wr_pend;
        end
    end

    // Payload registers of the transaction in progress.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_left    <= n_left;
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        r_status  <= n_status;
        r_value   <= n_value;
    end

    // Sequencer: next state, memory accesses and register updates.
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_pos     = r_pos;
        n_val     = r_val;
        n_fill    = r_fill;
        n_left    = r_left;
        n_rd_addr = r_rd_addr;
        n_wr_pend = r_wr_pend;
        n_wr_addr = r_wr_addr;
        n_status  = r_status;
        n_value   = r_value;
        mem_re    = 1'b0;
        mem_ra    = r_rd_addr;
        mem_we    = 1'b0;
        mem_wa    = r_wr_addr;
        mem_wd    = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = t_opcode'(i_opcode);
                    n_pos    = pos_x;
                    n_val    = i_value_in;
                    n_status = STATUS_ERR;
                    n_value  = '0;
                    n_state  = S_DONE;
                    unique case (t_opcode'(i_opcode))
                        OP_GET, OP_DELETE: begin
                            if (ok_read) begin
                                mem_re   = 1'b1;
                                mem_ra   = AW'(pos_x - 1'b1);
                                n_status = STATUS_OK;
                                n_state  = S_READ;
                            end
                        end
                        OP_INSERT: begin
                            if (ok_insert) begin
                                // Entries from the last one down to the target move up.
                                n_left    = FW'(fill_x - pos_x + 1'b1);
                                n_rd_addr = AW'(fill_x - 1'b1);
                                n_wr_pend = 1'b0;
                                n_status  = STATUS_OK;
                                n_state   = S_SHIFT;
                            end
                        end
                        default: begin
                            n_status = STATUS_ERR;
                        end
                    endcase
                end
            end

            S_READ: begin
                n_value = r_rd_data;
                if (r_op == OP_DELETE) begin
                    // Entries after the removed one move down.
                    n_left    = FW'(fill_x - r_pos);
                    n_rd_addr = AW'(r_pos);
                    n_wr_pend = 1'b0;
                    n_state   = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_SHIFT: begin
                // Write back the entry read in the previous cycle.
                if (r_wr_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_wr_addr;
                    mem_wd = r_rd_data;
                end
                if (r_left != '0) begin
                    mem_re    = 1'b1;
                    mem_ra    = r_rd_addr;
                    n_wr_pend = 1'b1;
                    n_left    = r_left - 1'b1;
                    if (is_insert) begin
                        n_wr_addr = r_rd_addr + 1'b1;
                        n_rd_addr = r_rd_addr - 1'b1;
                    end else begin
                        n_wr_addr = r_rd_addr - 1'b1;
                        n_rd_addr = r_rd_addr + 1'b1;
                    end
                end else begin
                    n_wr_pend = 1'b0;
                    if (is_insert) begin
                        n_state = S_PUT;
                    end else begin
                        n_fill  = r_fill - 1'b1;
                        n_state = S_DONE;
                    end
                end
            end

            S_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = AW'(r_pos - 1'b1);
                mem_wd  = r_val;
                n_fill  = r_fill + 1'b1;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.value  = r_value;
    assign o_res.count  = fill_x[COUNT_W-1:0];

endmodule

@@ rtl/positional_list_store_top.sv @@
// Top level of the positional list store: request channel, result channel and output register.
// Depends on plst_pkg and plst_engine.
//
// Usage: a fixed-capacity ordered list addressed by 1-based position. Each request
// transaction on the input channel (i_in_valid / o_in_stall) carries an opcode
// (get, insert, delete), a position and a value. Each request yields exactly one
// result transaction on the output channel (o_out_valid / i_out_stall) with a
// status, the element read or removed (zero on insert and on error) and the count.
// Requests are worked one at a time; o_in_stall is high while a request is in work.
// An error goes straight to its result; get reads its entry; delete reads the
// entry, then moves the later entries down; insert moves entries up, then writes the value.
// The entry memory has one read and one write port, so a shift moves one entry
// per cycle. The engine takes the next request in the cycle after it hands its
// result to the output register.
// A finished result sits in the output register; the next request is accepted
// while it waits. If the receiver stalls and that register is still full, the
// engine holds its result and keeps o_in_stall high until the register frees.
// Reset clears the list to empty and drops any pending result; the memory
// needs no clearing pass.
module positional_list_store_top #(
    parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_opcode,
    input  logic [plst_pkg::POS_W-1:0]         i_position,
    input  logic signed [plst_pkg::DATA_W-1:0] i_value_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_status,
    output logic signed [plst_pkg::DATA_W-1:0] o_value_out,
    output logic [plst_pkg::COUNT_W-1:0]       o_count
);
    import plst_pkg::*;

    logic    busy;
    logic    res_valid;
    logic    res_ready;
    t_result res;

    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;

    plst_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_value_in  (i_value_in),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // The output register takes a new result when empty or being drained.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_value_out = r_out.value;
    assign o_count     = r_out.count;

endmodule

@@ rtl/plst_checker.sv @@
// Port-level checker for the positional list store, bound to the top level.
// Depends on plst_pkg and positional_list_store_top.
module plst_checker #(
    parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic [1:0]                         i_opcode,
    input logic [plst_pkg::POS_W-1:0]         i_position,
    input logic signed [plst_pkg::DATA_W-1:0] i_value_in,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_status,
    input logic signed [plst_pkg::DATA_W-1:0] o_value_out,
    input logic [plst_pkg::COUNT_W-1:0]       o_count
);
    import plst_pkg::*;

    // A stalled request transaction stays valid and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=>
            (i_in_valid && $stable(i_opcode) && $stable(i_position) && $stable(i_value_in)))
        else $error("request changed while stalled");

    // A stalled result transaction stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_value_out) && $stable(o_count)))
        else $error("result changed while stalled");

    // A failed request never returns an element.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_ERR)) |-> (o_value_out == '0))
        else $error("error result carries a nonzero value");

    // The reported count never exceeds the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_count) <= CAPACITY))
        else $error("count above capacity");

    // After a request transaction the block is busy with it.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted without entering work");

endmodule

bind positional_list_store_top plst_checker #(.CAPACITY(CAPACITY)) u_plst_checker (.*);
